/* hdl/tricev_pkg.sv */
package tricev_pkg;

    // operating modes; the fourth code is rejected as invalid
    typedef enum logic [1:0] {
        MODE_ALTITUDE = 2'd0,
        MODE_MEDIAN   = 2'd1,
        MODE_BISECTOR = 2'd2
    } t_mode;

    localparam int MODE_BITS = 2;

endpackage

/* hdl/triangle_cevian_length.sv */
// Triangle cevian length: altitude, median or angle bisector of one triangle.
//
// Input transaction: i_mode, i_side_a, i_side_b, i_side_c, i_base_side are
// taken at a rising edge where start is high and busy is low. busy stays low,
// so a new triangle can be started in every cycle.
// Result transaction: o_length and o_invalid are shown for exactly one cycle,
// marked by o_valid, and are taken at the edge that ends that cycle.
// o_invalid flags a non-triangle, a zero base in altitude mode or an unused
// mode code; o_length is then zero. Lengths are floored and saturate at the
// largest code.
// Throughput is one triangle per cycle. Four stages build the radicand with
// pairwise multiplies; behind them come the bit-serial square root, one root
// bit per stage over 2*SIDE_BITS+4 stages, a saturation check, and the
// restoring divider, one quotient bit per stage over SIDE_BITS stages, ahead
// of the output register.
// Reset clears every valid bit in the pipeline; items in flight are dropped.
// The receiver cannot hold results off, so the pipeline never stalls.
module triangle_cevian_length #(
    parameter int SIDE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tricev_pkg::MODE_BITS-1:0]    i_mode,
    input  logic [SIDE_BITS-1:0]                i_side_a,
    input  logic [SIDE_BITS-1:0]                i_side_b,
    input  logic [SIDE_BITS-1:0]                i_side_c,
    input  logic [SIDE_BITS-1:0]                i_base_side,
    output logic                                o_valid,
    output logic [SIDE_BITS-1:0]                o_length,
    output logic                                o_invalid
);
    import tricev_pkg::*;

    localparam int N   = SIDE_BITS;
    localparam int H   = N + 2;        // factor width
    localparam int QW  = 2 * H;        // product and root width
    localparam int RW  = 4 * H;        // radicand width
    localparam int RMW = QW + 2;       // square root trial width
    localparam int DW  = N + 1;        // divisor width
    localparam int DV  = 2 * N + 1;    // divider remainder width

    assign busy = 1'b0;

    // ---------------- stage 1: sums, checks, factor selection
    logic [N:0]   w_ab, w_ac, w_bc, w_ta, w_tb, w_tc;
    logic [N+1:0] w_s;
    logic         w_ok, w_bad;
    logic [H-1:0] w_x0, w_x1, w_x2, w_x3;
    logic [DW-1:0] w_d;

    assign w_ab = {1'b0, i_side_a} + {1'b0, i_side_b};
    assign w_ac = {1'b0, i_side_a} + {1'b0, i_side_c};
    assign w_bc = {1'b0, i_side_b} + {1'b0, i_side_c};
    assign w_s  = {1'b0, w_ab} + {2'b00, i_side_c};
    assign w_ta = w_bc - {1'b0, i_side_a};
    assign w_tb = w_ac - {1'b0, i_side_b};
    assign w_tc = w_ab - {1'b0, i_side_c};
    assign w_ok = (w_ab > {1'b0, i_side_c}) && (w_ac > {1'b0, i_side_b})
               && (w_bc > {1'b0, i_side_a});

    always_comb begin
        w_bad = !w_ok;
        case (i_mode)
            MODE_ALTITUDE: begin
                w_x0 = H'(w_s);
                w_x1 = H'(w_ta);
                w_x2 = H'(w_tb);
                w_x3 = H'(w_tc);
                w_d  = {i_base_side, 1'b0};
                if (i_base_side == '0) begin
                    w_bad = 1'b1;
                end
            end
            MODE_MEDIAN: begin
                w_x0 = H'(i_side_b);
                w_x1 = H'(i_side_b);
                w_x2 = H'(i_side_c);
                w_x3 = H'(i_side_c);
                w_d  = DW'(2);
            end
            MODE_BISECTOR: begin
                w_x0 = H'(i_side_b);
                w_x1 = H'(i_side_c);
                w_x2 = H'(w_s);
                w_x3 = H'(w_ta);
                w_d  = w_bc;
            end
            default: begin
                w_x0  = H'(i_side_b);
                w_x1  = H'(i_side_c);
                w_x2  = H'(w_s);
                w_x3  = H'(w_ta);
                w_d   = w_bc;
                w_bad = 1'b1;
            end
        endcase
    end

    logic          r1_v, r1_bad, r1_med;
    logic [H-1:0]  r1_x0, r1_x1, r1_x2, r1_x3;
    logic [N-1:0]  r1_a;
    logic [DW-1:0] r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
        r1_bad <= w_bad;
        r1_med <= (i_mode == MODE_MEDIAN);
        r1_x0  <= w_x0;
        r1_x1  <= w_x1;
        r1_x2  <= w_x2;
        r1_x3  <= w_x3;
        r1_a   <= i_side_a;
        r1_d   <= w_d;
    end

    // ---------------- stage 2: pairwise products
    logic [QW-1:0]  w_p1, w_p2;
    logic [2*N-1:0] w_aa;
    assign w_p1 = r1_x0 * r1_x1;
    assign w_p2 = r1_x2 * r1_x3;
    assign w_aa = r1_a * r1_a;

    logic           r2_v, r2_bad, r2_med;
    logic [QW-1:0]  r2_p1, r2_p2;
    logic [2*N-1:0] r2_aa;
    logic [DW-1:0]  r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_bad <= r1_bad;
        r2_med <= r1_med;
        r2_p1  <= w_p1;
        r2_p2  <= w_p2;
        r2_aa  <= w_aa;
        r2_d   <= r1_d;
    end

    // ---------------- stage 3: median radicand, partial products of the rest
    logic [QW-1:0] w_medr, w_pll, w_plh, w_phl, w_phh;
    assign w_medr = ((r2_p1 + r2_p2) << 1) - QW'(r2_aa);
    assign w_pll  = r2_p1[H-1:0]  * r2_p2[H-1:0];
    assign w_plh  = r2_p1[H-1:0]  * r2_p2[QW-1:H];
    assign w_phl  = r2_p1[QW-1:H] * r2_p2[H-1:0];
    assign w_phh  = r2_p1[QW-1:H] * r2_p2[QW-1:H];

    logic          r3_v, r3_bad, r3_med;
    logic [QW-1:0] r3_medr, r3_pll, r3_plh, r3_phl, r3_phh;
    logic [DW-1:0] r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_bad  <= r2_bad;
        r3_med  <= r2_med;
        r3_medr <= w_medr;
        r3_pll  <= w_pll;
        r3_plh  <= w_plh;
        r3_phl  <= w_phl;
        r3_phh  <= w_phh;
        r3_d    <= r2_d;
    end

    // ---------------- stage 4: full radicand
    logic [RW-1:0] w_rad;
    assign w_rad = r3_med ? RW'(r3_medr)
                 : (RW'(r3_phh) << QW) + ((RW'(r3_plh) + RW'(r3_phl)) << H)
                   + RW'(r3_pll);

    logic          r_sq_v   [0:QW];
    logic          r_sq_bad [0:QW];
    logic [RW-1:0] r_sq_rad [0:QW];
    logic [QW-1:0] r_sq_rem [0:QW];
    logic [QW-1:0] r_sq_root[0:QW];
    logic [DW-1:0] r_sq_d   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r3_v;
        end
        r_sq_bad[0]  <= r3_bad;
        r_sq_rad[0]  <= w_rad;
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_d[0]    <= r3_d;
    end

    // ---------------- square root, one root bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_sqrt
        localparam int J = QW - 1 - k;
        logic [RMW-1:0] w_trem, w_trial;
        logic           w_take;
        assign w_trem  = {r_sq_rem[k], r_sq_rad[k][2*J+1:2*J]};
        assign w_trial = {r_sq_root[k], 2'b01};
        assign w_take  = (w_trem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_sq_bad[k+1]  <= r_sq_bad[k];
            r_sq_rad[k+1]  <= r_sq_rad[k];
            r_sq_d[k+1]    <= r_sq_d[k];
            if (w_take) begin
                r_sq_rem[k+1]  <= QW'(w_trem - w_trial);
                r_sq_root[k+1] <= {r_sq_root[k][QW-2:0], 1'b1};
            end else begin
                r_sq_rem[k+1]  <= w_trem[QW-1:0];
                r_sq_root[k+1] <= {r_sq_root[k][QW-2:0], 1'b0};
            end
        end
    end

    // ---------------- saturation check ahead of the divider
    logic [DV-1:0] w_lim;
    assign w_lim = {r_sq_d[QW], {N{1'b0}}};

    logic          r_dv_v   [0:N];
    logic          r_dv_bad [0:N];
    logic          r_dv_sat [0:N];
    logic [DV-1:0] r_dv_rem [0:N];
    logic [N-1:0]  r_dv_quo [0:N];
    logic [DW-1:0] r_dv_d   [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_sq_v[QW];
        end
        r_dv_bad[0] <= r_sq_bad[QW];
        r_dv_sat[0] <= (r_sq_root[QW] >= QW'(w_lim));
        r_dv_rem[0] <= r_sq_root[QW][DV-1:0];
        r_dv_quo[0] <= '0;
        r_dv_d[0]   <= r_sq_d[QW];
    end

    // ---------------- restoring divide, one quotient bit per stage
    for (genvar i = 0; i < N; i++) begin : g_div
        localparam int BP = N - 1 - i;
        logic [DV-1:0] w_sub;
        logic          w_take;
        assign w_sub  = DV'(r_dv_d[i]) << BP;
        assign w_take = (r_dv_rem[i] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[i+1] <= 1'b0;
            end else begin
                r_dv_v[i+1] <= r_dv_v[i];
            end
            r_dv_bad[i+1] <= r_dv_bad[i];
            r_dv_sat[i+1] <= r_dv_sat[i];
            r_dv_d[i+1]   <= r_dv_d[i];
            if (w_take) begin
                r_dv_rem[i+1] <= r_dv_rem[i] - w_sub;
                r_dv_quo[i+1] <= {r_dv_quo[i][N-2:0], 1'b1};
            end else begin
                r_dv_rem[i+1] <= r_dv_rem[i];
                r_dv_quo[i+1] <= {r_dv_quo[i][N-2:0], 1'b0};
            end
        end
    end

    // ---------------- output register
    logic         r_out_v, r_out_invalid;
    logic [N-1:0] r_out_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_dv_v[N];
        end
        r_out_invalid <= r_dv_bad[N];
        if (r_dv_bad[N]) begin
            r_out_length <= '0;
        end else if (r_dv_sat[N]) begin
            r_out_length <= '1;
        end else begin
            r_out_length <= r_dv_quo[N];
        end
    end

    assign o_valid   = r_out_v;
    assign o_length  = r_out_length;
    assign o_invalid = r_out_invalid;

endmodule

/* hdl/tricev_chk.sv */
module tricev_chk #(
    parameter int SIDE_BITS = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [tricev_pkg::MODE_BITS-1:0]    i_mode,
    input logic [SIDE_BITS-1:0]                i_base_side,
    input logic                                o_valid,
    input logic [SIDE_BITS-1:0]                o_length,
    input logic                                o_invalid
);
    import tricev_pkg::*;

    localparam int LAT = 3 * SIDE_BITS + 10;

    logic w_acc, w_bad_mode, w_zero_base;
    assign w_acc       = start && !busy;
    assign w_bad_mode  = (i_mode != MODE_ALTITUDE) && (i_mode != MODE_MEDIAN)
                      && (i_mode != MODE_BISECTOR);
    assign w_zero_base = (i_mode == MODE_ALTITUDE) && (i_base_side == '0);

    // every accepted transaction yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LAT o_valid)
        else $error("result missing after accepted transaction");

    // no result without a transaction accepted the fixed latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, LAT))
        else $error("result without matching transaction");

    // unused mode code or zero altitude base comes back flagged
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_bad_mode || w_zero_base)) |-> ##LAT (o_valid && o_invalid))
        else $error("rejected transaction not flagged invalid");

    // a flagged result carries a zero length
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_length == '0))
        else $error("invalid result with nonzero length");

endmodule

bind triangle_cevian_length tricev_chk #(.SIDE_BITS(SIDE_BITS)) u_tricev_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_mode      (i_mode),
    .i_base_side (i_base_side),
    .o_valid     (o_valid),
    .o_length    (o_length),
    .o_invalid   (o_invalid)
);

/* test/triangle_cevian_length_tb.sv */
module triangle_cevian_length_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tricev_pkg::*;

    localparam int SB = 16;
    localparam int LATENCY = 3 * SB + 9;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [SB-1:0] length;
        logic          invalid;
    } t_cevian;

    int unsigned n_errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // largest v <= 0xffff with (d*v)^2 + e <= r, exact in 128-bit arithmetic
    function automatic logic [SB-1:0] floor_root(input logic [127:0] d, input logic [127:0] e,
                                                  input logic [127:0] r);
        logic [127:0] lo, hi, mid, dv;
        lo = '0;
        hi = 128'((1 << SB) - 1);
        while (lo < hi) begin
            mid = lo + (hi - lo + 128'd1) / 128'd2;
            dv = d * mid;
            if (dv * dv + e <= r) lo = mid;
            else hi = mid - 128'd1;
        end
        return lo[SB-1:0];
    endfunction

    function automatic t_cevian cevian_of(input logic [1:0] mode, input logic [SB-1:0] a,
                                          input logic [SB-1:0] b, input logic [SB-1:0] c,
                                          input logic [SB-1:0] base);
        t_cevian res;
        logic [127:0] ea, eb, ec, eba, s, ta;
        logic bad;
        ea = 128'(a); eb = 128'(b); ec = 128'(c); eba = 128'(base);
        res.length = '0;
        bad = !((ea + eb > ec) && (ea + ec > eb) && (eb + ec > ea));
        if (mode == MODE_UNUSED || (mode == MODE_ALTITUDE && base == '0)) bad = 1'b1;
        res.invalid = bad;
        if (!bad) begin
            s = ea + eb + ec;
            ta = eb + ec - ea;
            case (mode)
                MODE_ALTITUDE: res.length = floor_root(128'd2 * eba, 128'd0,
                                   s * ta * (ea + ec - eb) * (ea + eb - ec));
                MODE_MEDIAN: res.length = floor_root(128'd2, ea * ea,
                                   128'd2 * (eb * eb + ec * ec));
                default: res.length = floor_root(eb + ec, 128'd0, eb * ec * s * ta);
            endcase
        end
        return res;
    endfunction

    class cevian_scoreboard;
        t_cevian pending[$];

        function void note_triangle(logic [1:0] mode, logic [SB-1:0] a, logic [SB-1:0] b,
                                    logic [SB-1:0] c, logic [SB-1:0] base);
            pending.push_back(cevian_of(mode, a, b, c, base));
        endfunction

        task check_result(logic [SB-1:0] length, logic invalid);
            t_cevian want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", length, -1);
            end else begin
                want = pending.pop_front();
                if (length !== want.length) report_mismatch("length", length, want.length);
                if (invalid !== want.invalid) report_mismatch("invalid", invalid, want.invalid);
            end
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic [MODE_BITS-1:0] i_mode = '0;
    logic [SB-1:0] i_side_a = '0, i_side_b = '0, i_side_c = '0, i_base_side = '0;
    logic o_valid;
    logic [SB-1:0] o_length;
    logic o_invalid;

    cevian_scoreboard board = new();

    always #2 i_clk = ~i_clk;

    triangle_cevian_length #(.SIDE_BITS(SB)) dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_length, o_invalid);
        if (i_rst_n && start && !busy)
            board.note_triangle(i_mode, i_side_a, i_side_b, i_side_c, i_base_side);
    end

    // one transaction, holding start through busy
    task automatic send_triangle(input logic [1:0] mode, input logic [SB-1:0] a,
                                 input logic [SB-1:0] b, input logic [SB-1:0] c,
                                 input logic [SB-1:0] base);
        i_mode <= mode;
        i_side_a <= a; i_side_b <= b; i_side_c <= c; i_base_side <= base;
        start <= 1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n != 0) begin
            start <= 0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic logic [SB-1:0] rand_side(input int unsigned scale);
        case ($urandom_range(0, 5))
            0: return SB'($urandom_range(0, 3));
            1: return SB'(32'hffff - $urandom_range(0, 3));
            2: return SB'($urandom_range(1, 255));
            default: return SB'($urandom_range(1, scale));
        endcase
    endfunction

    task automatic send_random();
        logic [1:0] mode;
        logic [SB-1:0] a, b, c, base;
        int unsigned scale;
        scale = ($urandom_range(0, 1) == 0) ? 32'hffff : 32'h0fff;
        mode = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        b = rand_side(scale);
        c = rand_side(scale);
        if ($urandom_range(0, 4) == 0) begin
            a = rand_side(scale);
        end else begin
            // a valid triangle: a strictly between |b-c| and b+c
            a = SB'($urandom_range((b > c ? b - c : c - b) + 1,
                                   (b + c - 1 > 32'hffff) ? 32'hffff : b + c - 1));
        end
        case ($urandom_range(0, 4))
            0: base = a;
            1: base = b;
            2: base = c;
            3: base = rand_side(32'hffff);
            default: base = SB'($urandom_range(0, 3));
        endcase
        send_triangle(mode, a, b, c, base);
    endtask

    initial begin
        int unsigned waited;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        send_triangle(MODE_ALTITUDE, 16'h0300, 16'h0400, 16'h0500, 16'h0500);
        send_triangle(MODE_ALTITUDE, 16'h0300, 16'h0400, 16'h0500, 16'h0000);
        send_triangle(MODE_ALTITUDE, 16'h0001, 16'h0001, 16'h0001, 16'hffff);
        send_triangle(MODE_ALTITUDE, 16'hffff, 16'hffff, 16'hffff, 16'h0001);
        send_triangle(MODE_ALTITUDE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_triangle(MODE_ALTITUDE, 16'h0200, 16'h0300, 16'h0400, 16'h0010);
        send_triangle(MODE_MEDIAN, 16'h0300, 16'h0400, 16'h0500, 16'h0000);
        send_triangle(MODE_MEDIAN, 16'h0001, 16'hffff, 16'hffff, 16'h0000);
        send_triangle(MODE_MEDIAN, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_triangle(MODE_MEDIAN, 16'h0000, 16'h0400, 16'h0400, 16'h0001);
        send_triangle(MODE_BISECTOR, 16'h0300, 16'h0400, 16'h0500, 16'h0000);
        send_triangle(MODE_BISECTOR, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
        send_triangle(MODE_BISECTOR, 16'h0001, 16'hffff, 16'hffff, 16'h1234);
        send_triangle(MODE_BISECTOR, 16'h0002, 16'h0001, 16'h0001, 16'h0000);
        send_triangle(MODE_MEDIAN, 16'h0005, 16'h0002, 16'h0002, 16'h0000);
        send_triangle(MODE_BISECTOR, 16'h0001, 16'h0000, 16'h0001, 16'h0000);
        send_triangle(MODE_UNUSED, 16'h0300, 16'h0400, 16'h0500, 16'h0500);
        send_triangle(MODE_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        for (int i = 0; i < 750; i++) begin
            if (i == 300) begin
                // hold off until the pipeline has drained
                start <= 0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end
            if (i >= 100) idle_gap();
            send_random();
        end
        start <= 0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 4 * LATENCY) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (LATENCY) @(negedge i_clk);
        if (n_errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
